FILE: hw/rtl/mwu_pkg.sv
// Shared types, widths and constants of the momentum weight update unit.
package mwu_pkg;

   // Field and datapath widths.
   localparam int SAMPLE_W = 16;
   localparam int SUM_W = 40;
   localparam int MEAN_W = 32;
   localparam int CHANGE_W = 32;
   localparam int RATE_W = 24;
   localparam int Q16_W = 17;
   localparam int DIV_CNT_W = $clog2(SUM_W);

   // Shared multiplier: signed A operand by signed B operand.
   localparam int MUL_A_W = 33;
   localparam int MUL_B_W = 25;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;

   // Configuration port.
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 24;

   // Default ensemble size limit.
   localparam int DEFAULT_MAX_ELEMENTS = 256;

   // Fixed-point constants.
   localparam logic [RATE_W-1:0] RATE_RESET = 24'd10486;
   localparam logic [Q16_W-1:0] ONE_Q16 = 17'h10000;
   localparam int RECIP_W = 16;
   // 52429 / 2^19 gives an exact floor of x / 10 for every x up to one.
   localparam logic [RECIP_W-1:0] TENTH_RECIP = 16'd52429;
   localparam int TENTH_SHIFT = 19;
   localparam int DELTA_SHIFT = 34;
   localparam int Q16_SHIFT = 16;

   // Configuration register indexes.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_INITIAL_RATE = 2'd0,
      CSR_MOMENTUM     = 2'd1,
      CSR_RATE_DECAY   = 2'd2
   } csr_index_type;

   // Operand selection of the shared multiplier.
   typedef enum logic [2:0] {
      MUL_DELTA = 3'd0,
      MUL_NEW   = 3'd1,
      MUL_OLD   = 3'd2,
      MUL_TENTH = 3'd3,
      MUL_RATE  = 3'd4
   } mul_op_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       accept;
      logic       div_load;
      logic       div_step;
      logic       mean_load;
      logic       mul_en;
      mul_op_type mul_op;
      logic       delta_load;
      logic       blend_load;
      logic       blend_add;
      logic       finish;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic div_done;
   } status_type;

endpackage

FILE: hw/rtl/mwu_ctrl.sv
// Sequencing state machine of the momentum weight update unit.
module mwu_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 req_last,
   input  mwu_pkg::status_type  status,
   output logic                 busy,
   output mwu_pkg::cmd_type     cmd
);

   typedef enum logic [9:0] {
      ST_IDLE      = 10'b00_0000_0001,
      ST_LOAD      = 10'b00_0000_0010,
      ST_DIVIDE    = 10'b00_0000_0100,
      ST_MEAN      = 10'b00_0000_1000,
      ST_MUL_DELTA = 10'b00_0001_0000,
      ST_DELTA     = 10'b00_0010_0000,
      ST_MUL_NEW   = 10'b00_0100_0000,
      ST_MUL_OLD   = 10'b00_1000_0000,
      ST_MUL_TENTH = 10'b01_0000_0000,
      ST_MUL_RATE  = 10'b10_0000_0000
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      finish_ff;
   logic      finish_in;

   // The last step of an ensemble writes back the results while the state
   // machine already returns to idle.
   assign busy = (state_ff != ST_IDLE) || finish_ff;

   // Next state and command decode.
   always_comb begin
      state_in = state_ff;
      finish_in = 1'b0;
      cmd = '0;
      cmd.mul_op = mwu_pkg::MUL_DELTA;
      cmd.finish = finish_ff;
      case (state_ff)
         ST_IDLE: begin
            cmd.accept = start && !finish_ff;
            if (start && !finish_ff && req_last) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            cmd.div_load = 1'b1;
            state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (status.div_done) begin
               state_in = ST_MEAN;
            end
         end
         ST_MEAN: begin
            cmd.mean_load = 1'b1;
            state_in = ST_MUL_DELTA;
         end
         ST_MUL_DELTA: begin
            cmd.mul_en = 1'b1;
            cmd.mul_op = mwu_pkg::MUL_DELTA;
            state_in = ST_DELTA;
         end
         ST_DELTA: begin
            cmd.delta_load = 1'b1;
            state_in = ST_MUL_NEW;
         end
         ST_MUL_NEW: begin
            cmd.mul_en = 1'b1;
            cmd.mul_op = mwu_pkg::MUL_NEW;
            state_in = ST_MUL_OLD;
         end
         ST_MUL_OLD: begin
            cmd.mul_en = 1'b1;
            cmd.mul_op = mwu_pkg::MUL_OLD;
            cmd.blend_load = 1'b1;
            state_in = ST_MUL_TENTH;
         end
         ST_MUL_TENTH: begin
            cmd.mul_en = 1'b1;
            cmd.mul_op = mwu_pkg::MUL_TENTH;
            cmd.blend_add = 1'b1;
            state_in = ST_MUL_RATE;
         end
         ST_MUL_RATE: begin
            cmd.mul_en = 1'b1;
            cmd.mul_op = mwu_pkg::MUL_RATE;
            finish_in = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         finish_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         finish_ff <= finish_in;
      end
   end

endmodule

FILE: hw/rtl/mwu_datapath.sv
// Accumulator, divider, shared multiplier and result registers.
module mwu_datapath #(
   parameter int MAX_ELEMENTS = mwu_pkg::DEFAULT_MAX_ELEMENTS
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  mwu_pkg::cmd_type                        cmd,
   output mwu_pkg::status_type                     status,
   input  logic signed [mwu_pkg::SAMPLE_W-1:0]     req_input_value,
   input  logic signed [mwu_pkg::SAMPLE_W-1:0]     req_lesson_value,
   input  logic                                    csr_write_enable,
   input  logic [mwu_pkg::CSR_IDX_W-1:0]           csr_index,
   input  logic [mwu_pkg::CSR_DATA_W-1:0]          csr_write_data,
   output logic                                    rsp_valid,
   output logic signed [mwu_pkg::CHANGE_W-1:0]     rsp_weight_change,
   output logic [mwu_pkg::RATE_W-1:0]              rsp_next_rate,
   output logic                                    rsp_overflowed
);

   localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ELEMENTS);
   localparam int SUM_W = mwu_pkg::SUM_W;
   localparam int MEAN_W = mwu_pkg::MEAN_W;
   localparam int CHANGE_W = mwu_pkg::CHANGE_W;
   localparam int RATE_W = mwu_pkg::RATE_W;
   localparam int Q16_W = mwu_pkg::Q16_W;
   localparam int MUL_A_W = mwu_pkg::MUL_A_W;
   localparam int MUL_B_W = mwu_pkg::MUL_B_W;
   localparam int MUL_P_W = mwu_pkg::MUL_P_W;
   localparam int DIV_CNT_W = mwu_pkg::DIV_CNT_W;
   localparam int Q16_SHIFT = mwu_pkg::Q16_SHIFT;
   localparam int TENTH_SHIFT = mwu_pkg::TENTH_SHIFT;
   localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
   localparam logic signed [CHANGE_W-1:0] CHANGE_MAX = {1'b0, {(CHANGE_W-1){1'b1}}};
   localparam logic signed [CHANGE_W-1:0] CHANGE_MIN = {1'b1, {(CHANGE_W-1){1'b0}}};

   // Configuration and adaptive state.
   logic [RATE_W-1:0]          rate_ff, rate_in;
   logic [Q16_W-1:0]           momentum_ff, momentum_in;
   logic [Q16_W-1:0]           rate_decay_ff, rate_decay_in;
   logic signed [CHANGE_W-1:0] prev_delta_ff, prev_delta_in;

   // Ensemble accumulation.
   logic signed [SUM_W-1:0]    sum_ff, sum_in;
   logic [CNT_W-1:0]           count_ff, count_in;
   logic                       ovf_ff, ovf_in;
   logic signed [2*mwu_pkg::SAMPLE_W-1:0] sample_product;
   logic signed [SUM_W:0]      sum_wide;
   logic signed [SUM_W-1:0]    sum_sat;
   logic                       room;

   // Divider.
   logic                       neg_ff, neg_in;
   logic [SUM_W-1:0]           dq_ff, dq_in;
   logic [CNT_W-1:0]           rem_ff, rem_in;
   logic [DIV_CNT_W-1:0]       div_cnt_ff, div_cnt_in;
   logic [CNT_W:0]             rem_shift;
   logic [CNT_W:0]             rem_diff;
   logic                       fits;

   // Arithmetic pipeline.
   logic signed [MEAN_W-1:0]   mean_ff, mean_in;
   logic signed [MUL_A_W-1:0]  mul_a;
   logic signed [MUL_B_W-1:0]  mul_b;
   logic signed [MUL_P_W-1:0]  prod_ff, prod_in;
   logic signed [CHANGE_W-1:0] delta_ff, delta_in;
   logic signed [MUL_P_W-1:0]  delta_wide;
   logic signed [MUL_P_W:0]    blend_ff, blend_in;
   logic signed [MUL_P_W:0]    blend_shift;
   logic signed [CHANGE_W-1:0] change_sat;
   logic [Q16_W-1:0]           m_clamp, d_clamp, one_minus_m, one_minus_d;
   logic [Q16_W-1:0]           tenth, factor;
   logic                       grow;
   logic [RATE_W-1:0]          rate_new;

   // Result registers.
   logic                       rsp_valid_ff;
   logic signed [CHANGE_W-1:0] rsp_change_ff;
   logic [RATE_W-1:0]          rsp_rate_ff;
   logic                       rsp_ovf_ff;

   // Accumulate one sample product with saturation at the sum range.
   always_comb begin
      sample_product = req_input_value * req_lesson_value;
      sum_wide = (SUM_W+1)'(sum_ff) + (SUM_W+1)'(sample_product);
      if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
         sum_sat = sum_wide[SUM_W] ? SUM_MIN : SUM_MAX;
      end else begin
         sum_sat = sum_wide[SUM_W-1:0];
      end
      room = count_ff < CNT_MAX;
   end

   // Clamp momentum and decay to one.
   always_comb begin
      m_clamp = (momentum_ff > mwu_pkg::ONE_Q16) ? mwu_pkg::ONE_Q16 : momentum_ff;
      d_clamp = (rate_decay_ff > mwu_pkg::ONE_Q16) ? mwu_pkg::ONE_Q16 : rate_decay_ff;
      one_minus_m = mwu_pkg::ONE_Q16 - m_clamp;
      one_minus_d = mwu_pkg::ONE_Q16 - d_clamp;
   end

   // Restoring division step on the magnitude of the sum.
   always_comb begin
      rem_shift = {rem_ff, dq_ff[SUM_W-1]};
      rem_diff = rem_shift - {1'b0, count_ff};
      fits = rem_shift >= {1'b0, count_ff};
      status.div_done = div_cnt_ff == DIV_CNT_W'(SUM_W - 1);
   end

   // Rate adaptation factor and saturated new rate.
   always_comb begin
      tenth = prod_ff[TENTH_SHIFT +: Q16_W];
      grow = delta_ff <= prev_delta_ff;
      factor = grow ? (mwu_pkg::ONE_Q16 + tenth) : d_clamp;
      if (|prod_ff[MUL_P_W-1:Q16_SHIFT+RATE_W]) begin
         rate_new = '1;
      end else begin
         rate_new = prod_ff[Q16_SHIFT +: RATE_W];
      end
   end

   // Floor of the blend by 2^16, saturated to the change range.
   always_comb begin
      blend_shift = blend_ff >>> Q16_SHIFT;
      if ((&blend_shift[MUL_P_W:CHANGE_W-1]) || !(|blend_shift[MUL_P_W:CHANGE_W-1])) begin
         change_sat = blend_shift[CHANGE_W-1:0];
      end else begin
         change_sat = blend_shift[MUL_P_W] ? CHANGE_MIN : CHANGE_MAX;
      end
   end

   // Operand selection of the shared multiplier.
   always_comb begin
      case (cmd.mul_op)
         mwu_pkg::MUL_DELTA: begin
            mul_a = MUL_A_W'(mean_ff);
            mul_b = $signed({1'b0, rate_ff});
         end
         mwu_pkg::MUL_NEW: begin
            mul_a = MUL_A_W'(delta_ff);
            mul_b = $signed(MUL_B_W'(one_minus_m));
         end
         mwu_pkg::MUL_OLD: begin
            mul_a = MUL_A_W'(prev_delta_ff);
            mul_b = $signed(MUL_B_W'(m_clamp));
         end
         mwu_pkg::MUL_TENTH: begin
            mul_a = $signed(MUL_A_W'(one_minus_d));
            mul_b = $signed(MUL_B_W'(mwu_pkg::TENTH_RECIP));
         end
         mwu_pkg::MUL_RATE: begin
            mul_a = $signed(MUL_A_W'(factor));
            mul_b = $signed({1'b0, rate_ff});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // Next values of the arithmetic pipeline.
   always_comb begin
      prod_in = cmd.mul_en ? (mul_a * mul_b) : prod_ff;
      // The rate is below 2^24 and the mean at most 2^30, so delta fits.
      delta_wide = prod_ff >>> mwu_pkg::DELTA_SHIFT;
      delta_in = cmd.delta_load ? CHANGE_W'(delta_wide) : delta_ff;
      if (cmd.mean_load) begin
         mean_in = neg_ff ? -$signed(dq_ff[MEAN_W-1:0]) : $signed(dq_ff[MEAN_W-1:0]);
      end else begin
         mean_in = mean_ff;
      end
      if (cmd.blend_load) begin
         blend_in = (MUL_P_W+1)'(prod_ff);
      end else if (cmd.blend_add) begin
         blend_in = blend_ff + (MUL_P_W+1)'(prod_ff);
      end else begin
         blend_in = blend_ff;
      end
   end

   // Next values of the divider.
   always_comb begin
      neg_in = neg_ff;
      dq_in = dq_ff;
      rem_in = rem_ff;
      div_cnt_in = div_cnt_ff;
      if (cmd.div_load) begin
         neg_in = sum_ff[SUM_W-1];
         dq_in = sum_ff[SUM_W-1] ? (SUM_W'(0) - sum_ff) : sum_ff;
         rem_in = '0;
         div_cnt_in = '0;
      end else if (cmd.div_step) begin
         rem_in = fits ? rem_diff[CNT_W-1:0] : rem_shift[CNT_W-1:0];
         dq_in = {dq_ff[SUM_W-2:0], fits};
         div_cnt_in = div_cnt_ff + 1'b1;
      end
   end

   // Next values of the ensemble and adaptive state.
   always_comb begin
      sum_in = sum_ff;
      count_in = count_ff;
      ovf_in = ovf_ff;
      rate_in = rate_ff;
      prev_delta_in = prev_delta_ff;
      momentum_in = momentum_ff;
      rate_decay_in = rate_decay_ff;
      if (cmd.finish) begin
         sum_in = '0;
         count_in = '0;
         ovf_in = 1'b0;
         rate_in = rate_new;
         prev_delta_in = delta_ff;
      end else if (cmd.accept) begin
         if (room) begin
            sum_in = sum_sat;
            count_in = count_ff + 1'b1;
         end else begin
            ovf_in = 1'b1;
         end
      end
      if (csr_write_enable) begin
         case (csr_index)
            mwu_pkg::CSR_INITIAL_RATE: rate_in = csr_write_data[RATE_W-1:0];
            mwu_pkg::CSR_MOMENTUM:     momentum_in = csr_write_data[Q16_W-1:0];
            mwu_pkg::CSR_RATE_DECAY:   rate_decay_in = csr_write_data[Q16_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Control and architectural state.
   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
         count_ff <= '0;
         ovf_ff <= 1'b0;
         rate_ff <= mwu_pkg::RATE_RESET;
         prev_delta_ff <= '0;
         momentum_ff <= '0;
         rate_decay_ff <= mwu_pkg::ONE_Q16;
         div_cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sum_ff <= sum_in;
         count_ff <= count_in;
         ovf_ff <= ovf_in;
         rate_ff <= rate_in;
         prev_delta_ff <= prev_delta_in;
         momentum_ff <= momentum_in;
         rate_decay_ff <= rate_decay_in;
         div_cnt_ff <= div_cnt_in;
         rsp_valid_ff <= cmd.finish;
      end
   end

   // Working registers and result payload.
   always_ff @(posedge clock) begin
      neg_ff <= neg_in;
      dq_ff <= dq_in;
      rem_ff <= rem_in;
      mean_ff <= mean_in;
      prod_ff <= prod_in;
      delta_ff <= delta_in;
      blend_ff <= blend_in;
      if (cmd.finish) begin
         rsp_change_ff <= change_sat;
         rsp_rate_ff <= rate_new;
         rsp_ovf_ff <= ovf_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_weight_change = rsp_change_ff;
   assign rsp_next_rate = rsp_rate_ff;
   assign rsp_overflowed = rsp_ovf_ff;

endmodule

FILE: hw/rtl/momentum_weight_update_unit.sv
// Top level of the momentum weight update unit.
// Items without the last mark transfer one per cycle while busy is low, and leave busy low.
// A closing item holds busy through divider load, 40 division steps, mean,
// five multiplier steps, delta capture and write-back; a new transfer can come once busy falls.
// Its result strobe lasts one cycle and comes as busy falls; the receiver cannot stall.
// Synchronous active-high reset clears the ensemble and restores the register defaults.
module momentum_weight_update_unit #(
   parameter int MAX_ELEMENTS = mwu_pkg::DEFAULT_MAX_ELEMENTS
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    start,
   output logic                                    busy,
   input  logic signed [mwu_pkg::SAMPLE_W-1:0]     req_input_value,
   input  logic signed [mwu_pkg::SAMPLE_W-1:0]     req_lesson_value,
   input  logic                                    req_last,
   output logic                                    rsp_valid,
   output logic signed [mwu_pkg::CHANGE_W-1:0]     rsp_weight_change,
   output logic [mwu_pkg::RATE_W-1:0]              rsp_next_rate,
   output logic                                    rsp_overflowed,
   input  logic                                    csr_write_enable,
   input  logic [mwu_pkg::CSR_IDX_W-1:0]           csr_index,
   input  logic [mwu_pkg::CSR_DATA_W-1:0]          csr_write_data
);

   mwu_pkg::cmd_type    cmd;
   mwu_pkg::status_type status;

   // Sequencer.
   mwu_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_last (req_last),
      .status   (status),
      .busy     (busy),
      .cmd      (cmd)
   );

   // Arithmetic and state.
   mwu_datapath #(
      .MAX_ELEMENTS (MAX_ELEMENTS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_input_value   (req_input_value),
      .req_lesson_value  (req_lesson_value),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .rsp_valid         (rsp_valid),
      .rsp_weight_change (rsp_weight_change),
      .rsp_next_rate     (rsp_next_rate),
      .rsp_overflowed    (rsp_overflowed)
   );

endmodule

FILE: hw/rtl/mwu_checker.sv
// Port-level checks of the momentum weight update unit and their binding.
module mwu_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic req_last,
   input logic rsp_valid
);

   // A result transfer never repeats in the next cycle.
   a_single_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for two cycles");

   // Busy rises only after a transfer that closes an ensemble.
   a_busy_after_last: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start && req_last))
      else $error("busy rose without a closing transfer");

   // A result appears exactly as busy falls.
   a_result_ends_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $fell(busy))
      else $error("result strobe not at the end of busy");

   // An item without the last mark leaves the unit free for the next cycle.
   a_stream_free: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && !req_last) |=> !busy)
      else $error("busy after a plain transfer");

endmodule

bind momentum_weight_update_unit mwu_checker u_mwu_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_last  (req_last),
   .rsp_valid (rsp_valid)
);

FILE: tb/momentum_weight_update_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of the momentum weight update unit.
module momentum_weight_update_unit_tb;

   localparam int SAMPLE_W = mwu_pkg::SAMPLE_W;
   localparam int SUM_W = mwu_pkg::SUM_W;
   localparam int CHANGE_W = mwu_pkg::CHANGE_W;
   localparam int RATE_W = mwu_pkg::RATE_W;
   localparam int Q16_W = mwu_pkg::Q16_W;
   localparam int CSR_IDX_W = mwu_pkg::CSR_IDX_W;
   localparam int CSR_DATA_W = mwu_pkg::CSR_DATA_W;
   localparam int DELTA_SHIFT = mwu_pkg::DELTA_SHIFT;
   localparam int Q16_SHIFT = mwu_pkg::Q16_SHIFT;
   localparam int MAX_PAIRS = mwu_pkg::DEFAULT_MAX_ELEMENTS;
   localparam int SETTLE_CYCLES = 60;
   localparam int CYCLE_LIMIT = 800000;
   localparam int RANDOM_PAIRS_PER_PHASE = 170;
   localparam longint SUM_HIGH = (longint'(1) <<< (SUM_W - 1)) - 1;
   localparam longint SUM_LOW = -(longint'(1) <<< (SUM_W - 1));
   localparam longint CHANGE_HIGH = (longint'(1) <<< (CHANGE_W - 1)) - 1;
   localparam longint CHANGE_LOW = -(longint'(1) <<< (CHANGE_W - 1));
   localparam longint RATE_HIGH = (longint'(1) <<< RATE_W) - 1;
   localparam longint UNITY = 65536;

   // One expected weight update, as the result port carries it.
   typedef struct packed {
      logic signed [CHANGE_W-1:0] weight_change;
      logic [RATE_W-1:0]          next_rate;
      logic                       overflowed;
   } weight_update_type;

   logic                         clock = 1'b0;
   logic                         reset;
   logic                         start;
   logic                         busy;
   logic signed [SAMPLE_W-1:0]   req_input_value;
   logic signed [SAMPLE_W-1:0]   req_lesson_value;
   logic                         req_last;
   logic                         rsp_valid;
   logic signed [CHANGE_W-1:0]   rsp_weight_change;
   logic [RATE_W-1:0]            rsp_next_rate;
   logic                         rsp_overflowed;
   logic                         csr_write_enable;
   logic [CSR_IDX_W-1:0]         csr_index;
   logic [CSR_DATA_W-1:0]        csr_write_data;

   // Expected updates in arrival order, and the predictor's copy of the state.
   weight_update_type            pending_updates[$];
   weight_update_type            oldest_update;
   logic signed [SUM_W-1:0]      product_total;
   int unsigned                  pairs_in_ensemble;
   logic [RATE_W-1:0]            current_rate;
   logic signed [CHANGE_W-1:0]   last_delta;
   logic                         pairs_dropped;
   logic [RATE_W-1:0]            start_rate_reg;
   logic [Q16_W-1:0]             momentum_reg;
   logic [Q16_W-1:0]             decay_reg;

   int                           fail_count = 0;
   int                           cycle_count = 0;
   int                           sender_idle_pct = 0;

   momentum_weight_update_unit #(
      .MAX_ELEMENTS(MAX_PAIRS)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_input_value(req_input_value),
      .req_lesson_value(req_lesson_value),
      .req_last(req_last),
      .rsp_valid(rsp_valid),
      .rsp_weight_change(rsp_weight_change),
      .rsp_next_rate(rsp_next_rate),
      .rsp_overflowed(rsp_overflowed),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   // Clock with a 4 ns period.
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Run watchdog.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   function automatic longint saturate32(input longint value);
      if (value > CHANGE_HIGH) return CHANGE_HIGH;
      if (value < CHANGE_LOW) return CHANGE_LOW;
      return value;
   endfunction

   function automatic longint clamp_to_one(input logic [Q16_W-1:0] value);
      return (longint'(value) > UNITY) ? UNITY : longint'(value);
   endfunction

   // Mirror a register write in the predictor.
   task automatic apply_register(input mwu_pkg::csr_index_type index,
                                 input logic [CSR_DATA_W-1:0] data);
      case (index)
         mwu_pkg::CSR_INITIAL_RATE: begin
            start_rate_reg = data[RATE_W-1:0];
            current_rate = data[RATE_W-1:0];
         end
         mwu_pkg::CSR_MOMENTUM: momentum_reg = data[Q16_W-1:0];
         mwu_pkg::CSR_RATE_DECAY: decay_reg = data[Q16_W-1:0];
         default: ;
      endcase
   endtask

   // Accumulate one pair; on the last pair, predict the weight update and adapt the rate.
   task automatic accumulate_pair(input logic signed [SAMPLE_W-1:0] sample,
                                  input logic signed [SAMPLE_W-1:0] lesson,
                                  input logic last);
      longint sum;
      longint mean;
      longint delta;
      longint blend;
      longint m;
      longint d;
      longint adapted;
      weight_update_type update;
      if (pairs_in_ensemble < MAX_PAIRS) begin
         sum = longint'(product_total) + longint'(sample) * longint'(lesson);
         if (sum > SUM_HIGH) sum = SUM_HIGH;
         if (sum < SUM_LOW) sum = SUM_LOW;
         product_total = SUM_W'(sum);
         pairs_in_ensemble++;
      end else begin
         pairs_dropped = 1'b1;
      end
      if (last) begin
         mean = 0;
         if (pairs_in_ensemble != 0)
            mean = longint'(product_total) / longint'(pairs_in_ensemble);
         delta = saturate32((longint'(current_rate) * mean) >>> DELTA_SHIFT);
         m = clamp_to_one(momentum_reg);
         d = clamp_to_one(decay_reg);
         blend = ((UNITY - m) * delta + m * longint'(last_delta)) >>> Q16_SHIFT;
         // The rate grows while the delta does not rise, and decays otherwise.
         if (delta <= longint'(last_delta))
            adapted = (longint'(current_rate) * (UNITY + (UNITY - d) / 10)) >>> Q16_SHIFT;
         else
            adapted = (longint'(current_rate) * d) >>> Q16_SHIFT;
         if (adapted > RATE_HIGH) adapted = RATE_HIGH;
         current_rate = RATE_W'(adapted);
         update.weight_change = CHANGE_W'(saturate32(blend));
         update.next_rate = current_rate;
         update.overflowed = pairs_dropped;
         pending_updates.push_back(update);
         last_delta = CHANGE_W'(delta);
         product_total = '0;
         pairs_in_ensemble = 0;
         pairs_dropped = 1'b0;
      end
   endtask

   task automatic report_field(input string label, input longint want, input longint got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d actual %0d", $time, label, want, got);
         fail_count++;
      end
   endtask

   // Compare every result transfer with the oldest expected update.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_updates.size() == 0) begin
            $display("%0t: unexpected result, expected none actual %0d/%0d/%0d", $time,
                     rsp_weight_change, rsp_next_rate, rsp_overflowed);
            fail_count++;
         end else begin
            oldest_update = pending_updates.pop_front();
            report_field("weight_change", longint'(oldest_update.weight_change),
                         longint'(rsp_weight_change));
            report_field("next_rate", longint'(oldest_update.next_rate),
                         longint'(rsp_next_rate));
            report_field("overflowed", longint'(oldest_update.overflowed),
                         longint'(rsp_overflowed));
         end
      end
   end

   // Send one pair and wait for its transfer; start stays high for a following pair.
   task automatic send_pair(input logic signed [SAMPLE_W-1:0] sample,
                            input logic signed [SAMPLE_W-1:0] lesson,
                            input logic last);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         @(negedge clock);
         start = 1'b0;
      end
      @(negedge clock);
      start = 1'b1;
      req_input_value = sample;
      req_lesson_value = lesson;
      req_last = last;
      do @(posedge clock); while (busy);
      accumulate_pair(sample, lesson, last);
   endtask

   // Stop sending and wait until every expected update has arrived.
   task automatic drain_updates();
      @(negedge clock);
      start = 1'b0;
      while (pending_updates.size() != 0) @(posedge clock);
   endtask

   // Drain and let the block settle so that registers may be written.
   task automatic settle_block();
      drain_updates();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input mwu_pkg::csr_index_type index,
                                 input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      start = 1'b0;
      csr_write_enable = 1'b1;
      csr_index = index;
      csr_write_data = data;
      apply_register(index, data);
      @(negedge clock);
      csr_write_enable = 1'b0;
   endtask

   task automatic write_all_registers(input logic [CSR_DATA_W-1:0] rate,
                                      input logic [CSR_DATA_W-1:0] momentum,
                                      input logic [CSR_DATA_W-1:0] decay);
      settle_block();
      write_register(mwu_pkg::CSR_INITIAL_RATE, rate);
      write_register(mwu_pkg::CSR_MOMENTUM, momentum);
      write_register(mwu_pkg::CSR_RATE_DECAY, decay);
   endtask

   // Random sample with extra weight on the extremes and on zero.
   function automatic logic signed [SAMPLE_W-1:0] random_sample();
      case ($urandom_range(0, 9))
         0: return 16'sh8000;
         1: return 16'sh7FFF;
         2: return 16'sh0000;
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   // One ensemble of random pairs, sometimes pausing until all updates are out.
   task automatic send_ensemble(input int length);
      for (int i = 0; i < length; i++) begin
         if ($urandom_range(0, 99) < 2) drain_updates();
         send_pair(random_sample(), random_sample(), i == length - 1);
      end
   endtask

   task automatic test_reset_defaults();
      sender_idle_pct = 20;
      send_pair(16'sh7FFF, 16'sh7FFF, 1'b1);
      send_pair(16'sh8000, 16'sh8000, 1'b1);
      send_pair(16'sh8000, 16'sh7FFF, 1'b0);
      send_pair(16'sh7FFF, 16'sh8000, 1'b1);
      send_pair(16'sh0000, 16'sh0000, 1'b1);
      send_pair(16'sh0001, 16'shFFFF, 1'b1);
   endtask

   // Register extremes: rate saturation, momentum and decay at and above one, and zero.
   task automatic test_config_extremes();
      write_all_registers(24'hFFFFFF, 24'h01FFFF, 24'h000000);
      send_pair(16'sh7FFF, 16'sh7FFF, 1'b1);
      send_pair(16'sh8000, 16'sh7FFF, 1'b1);
      send_pair(16'sh4000, 16'shC000, 1'b1);
      write_all_registers(24'h000000, 24'h010000, 24'h010000);
      send_pair(16'sh7FFF, 16'sh7FFF, 1'b1);
      send_pair(16'sh8000, 16'sh7FFF, 1'b1);
      write_all_registers(24'hFFFFFF, 24'h000000, 24'h01FFFF);
      send_pair(16'sh8000, 16'sh7FFF, 1'b1);
      send_pair(16'sh8000, 16'sh7FFF, 1'b1);
      send_pair(16'sh7FFF, 16'sh7FFF, 1'b1);
      write_all_registers(24'h0A0000, 24'h008000, 24'h00E000);
      send_pair(16'sh7FFF, 16'sh8000, 1'b0);
      send_pair(16'sh1234, 16'sh5678, 1'b1);
      send_pair(16'sh8000, 16'sh8000, 1'b1);
   endtask

   // Ensembles at the pair limit, one past it, well past it, and a short one after.
   task automatic test_ensemble_overflow();
      sender_idle_pct = 5;
      write_all_registers(24'h100000, 24'h004000, 24'h00C000);
      send_ensemble(MAX_PAIRS);
      send_ensemble(MAX_PAIRS + 1);
      send_ensemble(MAX_PAIRS + 9);
      send_ensemble(2);
   endtask

   task automatic run_random_phase(input int idle_pct);
      int sent;
      int length;
      int pick;
      sender_idle_pct = idle_pct;
      sent = 0;
      while (sent < RANDOM_PAIRS_PER_PHASE) begin
         pick = $urandom_range(0, 99);
         if (pick < 80) length = $urandom_range(1, 8);
         else if (pick < 95) length = $urandom_range(9, 40);
         else if (pick < 99) length = $urandom_range(41, MAX_PAIRS);
         else length = $urandom_range(MAX_PAIRS + 1, MAX_PAIRS + 20);
         send_ensemble(length);
         sent += length;
      end
   endtask

   task automatic test_random_traffic();
      write_all_registers(CSR_DATA_W'($urandom_range(1000, 400000)),
                          CSR_DATA_W'($urandom_range(0, 65536)),
                          CSR_DATA_W'($urandom_range(40000, 65536)));
      run_random_phase(8);
      write_all_registers(CSR_DATA_W'($urandom_range(1000, 2000000)),
                          CSR_DATA_W'($urandom_range(0, 65536)),
                          CSR_DATA_W'($urandom_range(0, 65536)));
      run_random_phase(52);
      write_all_registers(CSR_DATA_W'($urandom_range(1000, 400000)),
                          CSR_DATA_W'($urandom_range(0, 131071)),
                          CSR_DATA_W'($urandom_range(0, 131071)));
      run_random_phase(0);
   endtask

   // Main sequence.
   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_input_value = '0;
      req_lesson_value = '0;
      req_last = 1'b0;
      csr_write_enable = 1'b0;
      csr_index = '0;
      csr_write_data = '0;
      start_rate_reg = mwu_pkg::RATE_RESET;
      momentum_reg = '0;
      decay_reg = mwu_pkg::ONE_Q16;
      current_rate = mwu_pkg::RATE_RESET;
      product_total = '0;
      pairs_in_ensemble = 0;
      last_delta = '0;
      pairs_dropped = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_defaults();
      test_config_extremes();
      test_ensemble_overflow();
      test_random_traffic();
      settle_block();

      if (fail_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

FILE: sim.f
hw/rtl/mwu_pkg.sv
hw/rtl/mwu_ctrl.sv
hw/rtl/mwu_datapath.sv
hw/rtl/momentum_weight_update_unit.sv
hw/rtl/mwu_checker.sv
tb/momentum_weight_update_unit_tb.sv
